/* rtl/rnss_pkg.sv */
// Shared constants, types and the segment decoder for the radix seven-segment encoder.
`timescale 1ns / 1ps

package rnss_pkg;

   localparam int DISPLAY_DIGITS = 6;
   localparam int SLOTS          = 6;
   localparam int CONV_DIGITS    = (DISPLAY_DIGITS < SLOTS) ? DISPLAY_DIGITS : SLOTS;
   localparam int SEG_W          = 8;
   localparam int LOW_SLOTS      = 4;
   localparam int VALUE_W        = 32;
   localparam int LOW_W          = LOW_SLOTS * SEG_W;
   localparam int HIGH_W         = (SLOTS - LOW_SLOTS) * SEG_W;
   localparam int CNT_W          = $clog2(VALUE_W);
   localparam int RADIX_W        = 5;
   localparam int MOD_W          = 6;
   localparam int DIG_W          = 7;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
   localparam logic [MOD_W-1:0]   TIME_MOD    = 6'd60;
   localparam logic [VALUE_W-1:0] TIME_LIMIT  = 32'd6000;
   localparam logic [VALUE_W-1:0] MOST_NEG    = 32'h8000_0000;
   localparam logic [SEG_W-1:0]   SEG_BLANK   = 8'h00;

   localparam logic MODE_NUMBER = 1'b0;
   localparam logic MODE_TIME   = 1'b1;

   typedef struct packed {
      logic start;
      logic step;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic reject;
   } dp_status_type;

   function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
      logic [SEG_W-1:0] code;
      unique case (digit)
         4'h0: code = 8'h3F;
         4'h1: code = 8'h06;
         4'h2: code = 8'h5B;
         4'h3: code = 8'h4F;
         4'h4: code = 8'h66;
         4'h5: code = 8'h6D;
         4'h6: code = 8'h7D;
         4'h7: code = 8'h07;
         4'h8: code = 8'h7F;
         4'h9: code = 8'h6F;
         4'hA: code = 8'h77;
         4'hB: code = 8'h7C;
         4'hC: code = 8'h39;
         4'hD: code = 8'h5E;
         4'hE: code = 8'h79;
         default: code = 8'h71;
      endcase
      return code;
   endfunction

endpackage

/* rtl/rnss_if.sv */
// Channel interfaces: request, response and control-register write.
`timescale 1ns / 1ps

interface rnss_req_if import rnss_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      mode;

   modport source (output valid, output value, output mode, input ready);
   modport sink   (input valid, input value, input mode, output ready);
endinterface

interface rnss_rsp_if import rnss_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LOW_W-1:0]  seg_low;
   logic [HIGH_W-1:0] seg_high;
   logic              error;

   modport source (output valid, output seg_low, output seg_high, output error, input ready);
   modport sink   (input valid, input seg_low, input seg_high, input error, output ready);
endinterface

interface rnss_csr_if import rnss_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RADIX_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rnss_ctrl.sv */
// Controller: sequences accept, bit-serial conversion and result load.
`timescale 1ns / 1ps

module rnss_ctrl import rnss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             valid_ff, valid_in;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      valid_in  = valid_ff;
      cmd       = '0;
      req_ready = 1'b0;

      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.start = 1'b1;
               count_in  = '0;
               state_in  = status.reject ? ST_LOAD : ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_LAST) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // wait for the response slot to free up
            if (!valid_ff || rsp_ready) begin
               cmd.load = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

/* rtl/rnss_dp.sv */
// Datapath: radix register, bit-serial radix conversion, segment words.
`timescale 1ns / 1ps

module rnss_dp import rnss_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [RADIX_W-1:0]        csr_data,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_mode,
   input  ctrl_cmd_type              cmd,
   output dp_status_type             status,
   output logic [LOW_W-1:0]          seg_low,
   output logic [HIGH_W-1:0]         seg_high,
   output logic                      error
);

   logic [RADIX_W-1:0] radix_ff;
   logic [VALUE_W-1:0] mag_ff;
   logic [MOD_W-1:0]   mod_ff;
   logic               time_ff;
   logic               err_ff;
   logic               ovf_ff, ovf_in;
   logic [DIG_W-1:0]   dig_ff [CONV_DIGITS];
   logic [DIG_W-1:0]   dig_in [CONV_DIGITS];
   logic [LOW_W-1:0]   low_ff;
   logic [HIGH_W-1:0]  high_ff;
   logic               rsp_err_ff;

   logic [VALUE_W-1:0]    raw;
   logic [VALUE_W-1:0]    mag_start;
   logic [SLOTS*SEG_W-1:0] num_word;
   logic [LOW_W-1:0]      time_word;

   function automatic logic [3:0] tens_of(input logic [DIG_W-1:0] x);
      logic [3:0] n;
      n = '0;
      for (int k = 1; k <= 9; k++) begin
         if (x >= DIG_W'(10 * k)) begin
            n = n + 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic [3:0] ones_of(input logic [DIG_W-1:0] x);
      logic [DIG_W-1:0] rest;
      rest = x - DIG_W'(tens_of(x)) * DIG_W'(10);
      return rest[3:0];
   endfunction

   assign raw       = req_value;
   assign mag_start = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;

   always_comb begin
      if (req_mode == MODE_NUMBER) begin
         status.reject = (radix_ff < RADIX_MIN) || (radix_ff > RADIX_MAX)
                         || (raw == MOST_NEG);
      end else begin
         status.reject = raw[VALUE_W-1] || (raw >= TIME_LIMIT);
      end
   end

   // One magnitude bit per cycle, MSB first: each digit doubles, takes the carry,
   // and reduces by its modulus. Minutes in time mode are never reduced.
   always_comb begin
      logic             carry;
      logic [DIG_W:0]   t;
      logic [DIG_W:0]   lim;
      logic             reduce;
      carry  = mag_ff[VALUE_W-1];
      ovf_in = ovf_ff;
      for (int i = 0; i < CONV_DIGITS; i++) begin
         t      = {dig_ff[i], 1'b0} + (DIG_W+1)'(carry);
         lim    = (DIG_W+1)'(mod_ff);
         reduce = (i == 0) || !time_ff;
         if (reduce && (t >= lim)) begin
            t     = t - lim;
            carry = 1'b1;
         end else begin
            carry = 1'b0;
         end
         dig_in[i] = t[DIG_W-1:0];
      end
      ovf_in = ovf_ff | carry;
   end

   // Blank above the top nonzero digit, unless overflowed; digit 0 always shows.
   always_comb begin
      logic above;
      num_word = '0;
      above    = ovf_ff;
      for (int i = CONV_DIGITS - 1; i >= 0; i--) begin
         above = above || (dig_ff[i] != '0) || (i == 0);
         num_word[i*SEG_W +: SEG_W] = above ? seg_code(dig_ff[i][3:0]) : SEG_BLANK;
      end
   end

   assign time_word = {seg_code(tens_of(dig_ff[1])), seg_code(ones_of(dig_ff[1])),
                       seg_code(tens_of(dig_ff[0])), seg_code(ones_of(dig_ff[0]))};

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff   <= RADIX_RESET;
         low_ff     <= '0;
         high_ff    <= '0;
      end else begin
         if (csr_write) begin
            radix_ff <= csr_data;
         end
         if (cmd.load && !err_ff) begin
            if (time_ff) begin
               low_ff <= time_word;
            end else begin
               low_ff  <= num_word[LOW_W-1:0];
               high_ff <= num_word[SLOTS*SEG_W-1:LOW_W];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mag_ff  <= mag_start;
         mod_ff  <= (req_mode == MODE_TIME) ? TIME_MOD : MOD_W'(radix_ff);
         time_ff <= req_mode;
         err_ff  <= status.reject;
         ovf_ff  <= 1'b0;
         for (int i = 0; i < CONV_DIGITS; i++) begin
            dig_ff[i] <= '0;
         end
      end else if (cmd.step) begin
         mag_ff <= {mag_ff[VALUE_W-2:0], 1'b0};
         ovf_ff <= ovf_in;
         dig_ff <= dig_in;
      end
      if (cmd.load) begin
         rsp_err_ff <= err_ff;
      end
   end

   assign seg_low  = low_ff;
   assign seg_high = high_ff;
   assign error    = rsp_err_ff;

endmodule

/* rtl/radix_number_to_seven_segment.sv */
// Top level of the radix number to seven-segment encoder.
//
//   channel    dir   handshake      payload
//   req_chan   in    valid/ready    value[31:0] signed, mode
//   rsp_chan   out   valid/ready    seg_low[31:0], seg_high[15:0], error
//   csr_chan   in    valid/ready    data[4:0] (radix), ready outside reset
//
// An accepted transaction latches the request, shifts the magnitude through the
// digit registers one bit per cycle, and loads the result register once the
// response slot is free. A rejected transaction skips the shift.
// Reset restores radix 10 and clears both segment words.
// A new request is taken only while the controller is idle; a stalled response
// holds its result register while the next request converts.
`timescale 1ns / 1ps

module radix_number_to_seven_segment import rnss_pkg::*; (
   input logic         clock,
   input logic         reset,
   rnss_req_if.sink    req_chan,
   rnss_rsp_if.source  rsp_chan,
   rnss_csr_if.sink    csr_chan
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_chan.ready = !reset;

   rnss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rnss_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_chan.valid),
      .csr_data  (csr_chan.data),
      .req_value (req_chan.value),
      .req_mode  (req_chan.mode),
      .cmd       (cmd),
      .status    (status),
      .seg_low   (rsp_chan.seg_low),
      .seg_high  (rsp_chan.seg_high),
      .error     (rsp_chan.error)
   );

   // A fresh response appears only from a load.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.load))
      else $error("response raised without a load");

   // A rejected transaction leaves both segment words unchanged.
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_chan.valid) && rsp_chan.error)
         |-> ($stable(rsp_chan.seg_low) && $stable(rsp_chan.seg_high)))
      else $error("rejected transaction changed the segment words");

   // An accepted request converts unless rejected.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (cmd.step == !$past(status.reject)))
      else $error("conversion start does not match reject status");

endmodule
